// File: hw/rtl/csrast_pkg.sv
// Shared types, constants and codes of the cell shape rasterizer.
package csrast_pkg;

   localparam int MAX_COLUMNS_DEF = 64;
   localparam int MAX_ROWS_DEF    = 64;

   localparam int COORD_W   = 12;
   localparam int MASK_W    = 64;
   localparam int ROW_W     = 6;
   localparam int DIM_W     = 7;
   localparam int NUM_W     = 16;
   localparam int DEN_W     = 8;
   localparam int ROOT_W    = 6;
   localparam int STEP_W    = 5;
   localparam int DIV_STEPS  = 16;
   localparam int SQRT_STEPS = 6;

   typedef enum logic [1:0] {
      MODE_DISK = 2'd0,
      MODE_RING = 2'd1,
      MODE_LINE = 2'd2,
      MODE_RECT = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      CSR_SCREEN_WIDTH  = 2'd0,
      CSR_SCREEN_HEIGHT = 2'd1,
      CSR_OFFSET_X      = 2'd2,
      CSR_OFFSET_Y      = 2'd3
   } csr_index_type;

   typedef enum logic {
      OP_DIV  = 1'b0,
      OP_SQRT = 1'b1
   } iter_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ROW_START,
      ST_ROW_PREP,
      ST_A_GO,
      ST_A_WAIT,
      ST_B_GO,
      ST_B_WAIT,
      ST_ROW_MASK,
      ST_ROW_EMIT,
      ST_FLUSH
   } state_type;

   typedef logic signed [COORD_W-1:0] coord_type;

   // two inclusive column spans of one screen row
   typedef struct packed {
      coord_type lo0;
      coord_type hi0;
      coord_type lo1;
      coord_type hi1;
   } span_type;

   localparam span_type SPAN_EMPTY = '{lo0: 12'sd1, hi0: 12'sd0, lo1: 12'sd1, hi1: 12'sd0};

   typedef struct packed {
      logic             start;
      iter_op_type      op;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } iter_req_type;

   typedef struct packed {
      logic             done;
      logic [NUM_W-1:0] result;
   } iter_rsp_type;

endpackage

// File: hw/rtl/csrast_iter.sv
// Shared iterative unit: restoring divide (one bit a cycle) and integer square root.
module csrast_iter (
   input  logic                      clock,
   input  logic                      reset,
   input  csrast_pkg::iter_req_type  req,
   output csrast_pkg::iter_rsp_type  rsp
);

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   csrast_pkg::iter_op_type             op_ff, op_in;
   logic [csrast_pkg::STEP_W-1:0]       cnt_ff, cnt_in;
   logic [csrast_pkg::NUM_W-1:0]        num_ff, num_in;
   logic [csrast_pkg::DEN_W-1:0]        den_ff, den_in;
   logic [csrast_pkg::DEN_W-1:0]        rem_ff, rem_in;
   logic [csrast_pkg::NUM_W-1:0]        quot_ff, quot_in;

   logic [csrast_pkg::DEN_W:0]          trial;
   logic [csrast_pkg::DEN_W:0]          diff;
   logic                                fits;
   logic [2:0]                          bit_idx;
   logic [csrast_pkg::ROOT_W-1:0]       cand;
   logic [2*csrast_pkg::ROOT_W-1:0]     cand_sq;
   logic                                keep;

   // divide step: shift in next numerator bit, subtract when it fits
   assign trial = {rem_ff, num_ff[csrast_pkg::NUM_W-1]};
   assign fits  = trial >= {1'b0, den_ff};
   assign diff  = trial - {1'b0, den_ff};

   // root step: try the next lower bit of the root
   assign bit_idx = 3'(cnt_ff - csrast_pkg::STEP_W'(1));
   assign cand    = quot_ff[csrast_pkg::ROOT_W-1:0] | (csrast_pkg::ROOT_W'(1) << bit_idx);
   assign cand_sq = (2*csrast_pkg::ROOT_W)'(cand) * (2*csrast_pkg::ROOT_W)'(cand);
   assign keep    = csrast_pkg::NUM_W'(cand_sq) <= num_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      if (req.start) begin
         busy_in = 1'b1;
         op_in   = req.op;
         num_in  = req.num;
         den_in  = req.den;
         rem_in  = '0;
         quot_in = '0;
         cnt_in  = (req.op == csrast_pkg::OP_DIV) ? csrast_pkg::STEP_W'(csrast_pkg::DIV_STEPS)
                                                  : csrast_pkg::STEP_W'(csrast_pkg::SQRT_STEPS);
      end else if (busy_ff) begin
         case (op_ff)
            csrast_pkg::OP_DIV: begin
               rem_in  = fits ? diff[csrast_pkg::DEN_W-1:0] : trial[csrast_pkg::DEN_W-1:0];
               num_in  = num_ff << 1;
               quot_in = {quot_ff[csrast_pkg::NUM_W-2:0], fits};
            end
            csrast_pkg::OP_SQRT: begin
               if (keep) begin
                  quot_in = csrast_pkg::NUM_W'(cand);
               end
            end
            default: begin
               quot_in = quot_ff;
            end
         endcase
         cnt_in = cnt_ff - csrast_pkg::STEP_W'(1);
         if (cnt_ff == csrast_pkg::STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      op_ff   <= op_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.result = quot_ff;

endmodule

// File: hw/rtl/csrast_mask.sv
// Column mask builder: two clipped spans of one row to a 64-bit mask.
module csrast_mask (
   input  csrast_pkg::span_type           span,
   input  logic [csrast_pkg::DIM_W-1:0]   vis_w,
   output logic [csrast_pkg::MASK_W-1:0]  mask
);

   always_comb begin
      csrast_pkg::coord_type kk;
      kk = '0;
      for (int k = 0; k < csrast_pkg::MASK_W; k++) begin
         kk = csrast_pkg::coord_type'(k);
         mask[k] = ((kk >= span.lo0 && kk <= span.hi0) || (kk >= span.lo1 && kk <= span.hi1))
                   && (csrast_pkg::DIM_W'(k) < vis_w);
      end
   end

endmodule

// File: hw/rtl/cell_shape_rasterizer.sv
// Top level of the cell shape rasterizer: sequencer, registers and result stage.
//
// One req_ transfer carries one shape (disk, ring, line or rectangle). The block
// walks the visible screen rows from 0 upward and sends one rsp_ transfer for
// every row that holds at least one painted cell, in ascending row order;
// rsp_last marks the final row of the shape. A shape that covers nothing sends
// no transfer. req_stall stays high from acceptance until the last row has been
// handed to the result register.
// Rectangles, empty rows and level lines need no call to the shared unit; a covered
// disk row takes one 6-step square root, a covered ring row one or two, a steep
// line row one 16-step divide and a shallow line row two divides, all on the one
// shared unit.
// A one-entry row buffer looks ahead for rsp_last, so
// the first result leaves once the second non-empty row (or the end) is found.
// A stalled receiver holds the result register; the sequencer then waits at
// the next non-empty row. csr_ writes are always taken (csr_ready is high) and
// must only be issued while the block is idle. Reset sets a 30 by 30 screen,
// zero offsets, and empties the result register.
module cell_shape_rasterizer #(
   parameter int MAX_COLUMNS = csrast_pkg::MAX_COLUMNS_DEF,
   parameter int MAX_ROWS    = csrast_pkg::MAX_ROWS_DEF
) (
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_mode,
   input  logic [7:0]         req_glyph,
   input  logic [7:0]         req_color,
   input  logic signed [7:0]  req_pos_x,
   input  logic signed [7:0]  req_pos_y,
   input  logic signed [7:0]  req_end_x,
   input  logic signed [7:0]  req_end_y,
   input  logic [4:0]         req_radius,
   input  logic [6:0]         req_rect_width,
   input  logic [6:0]         req_rect_height,

   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [5:0]         rsp_row,
   output logic [63:0]        rsp_column_mask,
   output logic [7:0]         rsp_glyph_res,
   output logic [7:0]         rsp_paint_color,
   output logic               rsp_last,

   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [7:0]         csr_wdata
);

   localparam int CW = csrast_pkg::COORD_W;
   localparam int MW = csrast_pkg::MASK_W;
   localparam int RW = csrast_pkg::ROW_W;
   localparam int DW = csrast_pkg::DIM_W;
   localparam int NW = csrast_pkg::NUM_W;

   // configuration
   logic [DW-1:0]    scr_w_ff, scr_w_in;
   logic [DW-1:0]    scr_h_ff, scr_h_in;
   logic signed [7:0] ofs_x_ff, ofs_x_in;
   logic signed [7:0] ofs_y_ff, ofs_y_in;
   logic [DW-1:0]    vis_w;
   logic [DW-1:0]    vis_h;

   // item registers
   csrast_pkg::state_type  state_ff, state_in;
   csrast_pkg::mode_type   mode_ff, mode_in;
   logic [7:0]             glyph_ff, glyph_in;
   logic [7:0]             color_ff, color_in;
   logic [4:0]             r_ff, r_in;
   logic [6:0]             rw_ff, rw_in;
   logic [6:0]             rh_ff, rh_in;
   csrast_pkg::coord_type  cx_ff, cx_in;
   csrast_pkg::coord_type  py_ff, py_in;
   csrast_pkg::coord_type  x1s_ff, x1s_in;
   csrast_pkg::coord_type  y1_ff, y1_in;
   logic [7:0]             len_ff, len_in;
   logic [7:0]             alen_ff, alen_in;
   logic                   neg_ff, neg_in;
   logic                   xmaj_ff, xmaj_in;
   logic                   zero_ff, zero_in;

   // row registers
   logic [RW-1:0]          y_ff, y_in;
   logic [7:0]             m_ff, m_in;
   logic [NW-1:0]          opa_ff, opa_in;
   logic [NW-1:0]          opb_ff, opb_in;
   logic                   inner_ff, inner_in;
   logic [NW-1:0]          res_a_ff, res_a_in;
   csrast_pkg::span_type   span_ff, span_in;

   // lookahead buffer and result register
   logic                   hold_valid_ff, hold_valid_in;
   logic [RW-1:0]          hold_row_ff, hold_row_in;
   logic [MW-1:0]          hold_mask_ff, hold_mask_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RW-1:0]          rsp_row_ff, rsp_row_in;
   logic [MW-1:0]          rsp_mask_ff, rsp_mask_in;
   logic [7:0]             rsp_glyph_ff, rsp_glyph_in;
   logic [7:0]             rsp_color_ff, rsp_color_in;
   logic                   rsp_last_ff, rsp_last_in;

   csrast_pkg::iter_req_type  iter_req;
   csrast_pkg::iter_rsp_type  iter_rsp;
   logic [MW-1:0]             row_mask;

   // line setup from the request
   logic signed [8:0]      w9, h9, minor9;
   logic [8:0]             aw9, ah9;
   logic                   l_xmaj, l_swap;
   logic signed [7:0]      l_x1, l_y1;

   // row geometry
   csrast_pkg::coord_type  wy, di, adi, dy, ady;
   logic [9:0]             rr;
   logic [9:0]             ii;
   csrast_pkg::coord_type  bo_c, a_c;
   logic [NW-1:0]          prod;
   csrast_pkg::coord_type  jo, jin, tlo, tb, lm1, thi, qq;
   logic                   out_free;
   logic                   row_end;

   // configuration port
   assign csr_ready = 1'b1;

   always_comb begin
      scr_w_in = scr_w_ff;
      scr_h_in = scr_h_ff;
      ofs_x_in = ofs_x_ff;
      ofs_y_in = ofs_y_ff;
      if (csr_valid && csr_ready) begin
         case (csrast_pkg::csr_index_type'(csr_index))
            csrast_pkg::CSR_SCREEN_WIDTH:  scr_w_in = csr_wdata[DW-1:0];
            csrast_pkg::CSR_SCREEN_HEIGHT: scr_h_in = csr_wdata[DW-1:0];
            csrast_pkg::CSR_OFFSET_X:      ofs_x_in = csr_wdata;
            csrast_pkg::CSR_OFFSET_Y:      ofs_y_in = csr_wdata;
            default:                       scr_w_in = scr_w_ff;
         endcase
      end
   end

   assign vis_w = (scr_w_ff > DW'(MAX_COLUMNS)) ? DW'(MAX_COLUMNS) : scr_w_ff;
   assign vis_h = (scr_h_ff > DW'(MAX_ROWS)) ? DW'(MAX_ROWS) : scr_h_ff;

   // line orientation, swap and lengths
   assign w9     = 9'(req_end_x) - 9'(req_pos_x);
   assign h9     = 9'(req_end_y) - 9'(req_pos_y);
   assign aw9    = w9[8] ? 9'(-w9) : 9'(w9);
   assign ah9    = h9[8] ? 9'(-h9) : 9'(h9);
   assign l_xmaj = aw9 > ah9;
   assign l_swap = l_xmaj ? w9[8] : h9[8];
   assign l_x1   = l_swap ? req_end_x : req_pos_x;
   assign l_y1   = l_swap ? req_end_y : req_pos_y;
   assign minor9 = l_xmaj ? h9 : w9;

   // row geometry in world coordinates
   assign wy  = csrast_pkg::coord_type'(y_ff) - csrast_pkg::coord_type'(ofs_y_ff);
   assign di  = wy - py_ff;
   assign adi = di[CW-1] ? -di : di;
   assign dy  = wy - y1_ff;
   assign ady = dy[CW-1] ? -dy : dy;

   assign rr   = 10'(r_ff) * 10'(r_ff);
   assign ii   = 10'(m_ff[4:0]) * 10'(m_ff[4:0]);
   assign bo_c = csrast_pkg::coord_type'(rr)
                 + ((mode_ff == csrast_pkg::MODE_RING) ? csrast_pkg::coord_type'(r_ff) : '0)
                 - csrast_pkg::coord_type'(ii);
   assign a_c  = csrast_pkg::coord_type'(rr) - csrast_pkg::coord_type'(r_ff)
                 - csrast_pkg::coord_type'(ii);
   assign prod = NW'(m_ff) * NW'(xmaj_ff ? len_ff : alen_ff);

   assign jo  = csrast_pkg::coord_type'(res_a_ff[csrast_pkg::ROOT_W-1:0]);
   assign jin = inner_ff ? csrast_pkg::coord_type'(iter_rsp.result[csrast_pkg::ROOT_W-1:0])
                           + csrast_pkg::coord_type'(1) : '0;
   assign tlo = csrast_pkg::coord_type'(res_a_ff[9:0]);
   assign tb  = csrast_pkg::coord_type'(iter_rsp.result[9:0]) - csrast_pkg::coord_type'(1);
   assign lm1 = csrast_pkg::coord_type'(len_ff) - csrast_pkg::coord_type'(1);
   assign thi = (tb < lm1) ? tb : lm1;
   assign qq  = csrast_pkg::coord_type'(res_a_ff[9:0]);

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign row_end  = (DW'(y_ff) + DW'(1)) == vis_h;

   csrast_iter u_iter (
      .clock (clock),
      .reset (reset),
      .req   (iter_req),
      .rsp   (iter_rsp)
   );

   csrast_mask u_mask (
      .span  (span_ff),
      .vis_w (vis_w),
      .mask  (row_mask)
   );

   // sequencer: next state and outputs
   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      glyph_in      = glyph_ff;
      color_in      = color_ff;
      r_in          = r_ff;
      rw_in         = rw_ff;
      rh_in         = rh_ff;
      cx_in         = cx_ff;
      py_in         = py_ff;
      x1s_in        = x1s_ff;
      y1_in         = y1_ff;
      len_in        = len_ff;
      alen_in       = alen_ff;
      neg_in        = neg_ff;
      xmaj_in       = xmaj_ff;
      zero_in       = zero_ff;
      y_in          = y_ff;
      m_in          = m_ff;
      opa_in        = opa_ff;
      opb_in        = opb_ff;
      inner_in      = inner_ff;
      res_a_in      = res_a_ff;
      span_in       = span_ff;
      hold_valid_in = hold_valid_ff;
      hold_row_in   = hold_row_ff;
      hold_mask_in  = hold_mask_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_row_in    = rsp_row_ff;
      rsp_mask_in   = rsp_mask_ff;
      rsp_glyph_in  = rsp_glyph_ff;
      rsp_color_in  = rsp_color_ff;
      rsp_last_in   = rsp_last_ff;
      req_stall     = 1'b1;
      iter_req      = '{start: 1'b0, op: csrast_pkg::OP_DIV, num: '0, den: '0};

      case (state_ff)
         csrast_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               mode_in  = csrast_pkg::mode_type'(req_mode);
               glyph_in = req_glyph;
               color_in = req_color;
               r_in     = req_radius;
               rw_in    = req_rect_width;
               rh_in    = req_rect_height;
               cx_in    = csrast_pkg::coord_type'(req_pos_x)
                          + csrast_pkg::coord_type'(ofs_x_ff);
               py_in    = csrast_pkg::coord_type'(req_pos_y);
               x1s_in   = csrast_pkg::coord_type'(l_x1) + csrast_pkg::coord_type'(ofs_x_ff);
               y1_in    = csrast_pkg::coord_type'(l_y1);
               xmaj_in  = l_xmaj;
               len_in   = l_xmaj ? aw9[7:0] : ah9[7:0];
               alen_in  = l_xmaj ? ah9[7:0] : aw9[7:0];
               neg_in   = (minor9 != 9'sd0) && (minor9[8] ^ l_swap);
               zero_in  = (w9 == 9'sd0) && (h9 == 9'sd0);
               y_in     = '0;
               state_in = (vis_h == '0) ? csrast_pkg::ST_FLUSH : csrast_pkg::ST_ROW_START;
            end
         end

         // decide whether the row needs the shared unit, else set its span now
         csrast_pkg::ST_ROW_START: begin
            span_in  = csrast_pkg::SPAN_EMPTY;
            state_in = csrast_pkg::ST_ROW_EMIT;
            case (mode_ff)
               csrast_pkg::MODE_DISK, csrast_pkg::MODE_RING: begin
                  if (adi <= csrast_pkg::coord_type'(r_ff)) begin
                     m_in     = adi[7:0];
                     state_in = csrast_pkg::ST_ROW_PREP;
                  end
               end
               csrast_pkg::MODE_RECT: begin
                  if (!di[CW-1] && di < csrast_pkg::coord_type'(rh_ff)) begin
                     span_in.lo0 = cx_ff;
                     span_in.hi0 = cx_ff + csrast_pkg::coord_type'(rw_ff)
                                   - csrast_pkg::coord_type'(1);
                  end
               end
               csrast_pkg::MODE_LINE: begin
                  if (zero_ff) begin
                     if (dy == '0) begin
                        span_in.lo0 = x1s_ff;
                        span_in.hi0 = x1s_ff;
                     end
                  end else if (xmaj_ff) begin
                     if (alen_ff == '0) begin
                        if (dy == '0) begin
                           span_in.lo0 = x1s_ff;
                           span_in.hi0 = x1s_ff + lm1;
                        end
                     end else if ((neg_ff ? (dy[CW-1] || dy == '0) : !dy[CW-1])
                                  && ady <= csrast_pkg::coord_type'(alen_ff)) begin
                        m_in     = ady[7:0];
                        state_in = csrast_pkg::ST_ROW_PREP;
                     end
                  end else if (!dy[CW-1] && dy < csrast_pkg::coord_type'(len_ff)) begin
                     m_in     = dy[7:0];
                     state_in = csrast_pkg::ST_ROW_PREP;
                  end
               end
               default: state_in = csrast_pkg::ST_ROW_EMIT;
            endcase
         end

         // square or product ahead of the shared unit
         csrast_pkg::ST_ROW_PREP: begin
            if (mode_ff == csrast_pkg::MODE_LINE) begin
               opa_in   = prod;
               inner_in = 1'b0;
            end else begin
               opa_in   = NW'(bo_c);
               opb_in   = NW'(a_c - csrast_pkg::coord_type'(1));
               inner_in = (mode_ff == csrast_pkg::MODE_RING) && !a_c[CW-1] && (a_c != '0);
            end
            state_in = csrast_pkg::ST_A_GO;
         end

         csrast_pkg::ST_A_GO: begin
            iter_req.start = 1'b1;
            if (mode_ff == csrast_pkg::MODE_LINE) begin
               iter_req.op  = csrast_pkg::OP_DIV;
               iter_req.num = xmaj_ff ? NW'(opa_ff + NW'(alen_ff) - NW'(1)) : opa_ff;
               iter_req.den = xmaj_ff ? alen_ff : len_ff;
            end else begin
               iter_req.op  = csrast_pkg::OP_SQRT;
               iter_req.num = opa_ff;
            end
            state_in = csrast_pkg::ST_A_WAIT;
         end

         csrast_pkg::ST_A_WAIT: begin
            if (iter_rsp.done) begin
               res_a_in = iter_rsp.result;
               if (inner_ff || (mode_ff == csrast_pkg::MODE_LINE && xmaj_ff)) begin
                  state_in = csrast_pkg::ST_B_GO;
               end else begin
                  state_in = csrast_pkg::ST_ROW_MASK;
               end
            end
         end

         csrast_pkg::ST_B_GO: begin
            iter_req.start = 1'b1;
            if (mode_ff == csrast_pkg::MODE_LINE) begin
               iter_req.op  = csrast_pkg::OP_DIV;
               iter_req.num = NW'(opa_ff + NW'(len_ff) + NW'(alen_ff) - NW'(1));
               iter_req.den = alen_ff;
            end else begin
               iter_req.op  = csrast_pkg::OP_SQRT;
               iter_req.num = opb_ff;
            end
            state_in = csrast_pkg::ST_B_WAIT;
         end

         csrast_pkg::ST_B_WAIT: begin
            if (iter_rsp.done) begin
               state_in = csrast_pkg::ST_ROW_MASK;
            end
         end

         // turn unit results into column spans
         csrast_pkg::ST_ROW_MASK: begin
            span_in = csrast_pkg::SPAN_EMPTY;
            case (mode_ff)
               csrast_pkg::MODE_DISK: begin
                  span_in.lo0 = cx_ff - jo;
                  span_in.hi0 = cx_ff + jo;
               end
               csrast_pkg::MODE_RING: begin
                  span_in.lo0 = cx_ff - jo;
                  span_in.hi0 = cx_ff - jin;
                  span_in.lo1 = cx_ff + jin;
                  span_in.hi1 = cx_ff + jo;
               end
               csrast_pkg::MODE_LINE: begin
                  if (xmaj_ff) begin
                     span_in.lo0 = x1s_ff + tlo;
                     span_in.hi0 = x1s_ff + thi;
                  end else begin
                     span_in.lo0 = neg_ff ? x1s_ff - qq : x1s_ff + qq;
                     span_in.hi0 = span_in.lo0;
                  end
               end
               default: span_in = csrast_pkg::SPAN_EMPTY;
            endcase
            state_in = csrast_pkg::ST_ROW_EMIT;
         end

         // buffer a non-empty row, pushing the previous one out first
         csrast_pkg::ST_ROW_EMIT: begin
            if (row_mask == '0 || !hold_valid_ff || out_free) begin
               if (row_mask != '0) begin
                  if (hold_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_row_in   = hold_row_ff;
                     rsp_mask_in  = hold_mask_ff;
                     rsp_glyph_in = glyph_ff;
                     rsp_color_in = color_ff;
                     rsp_last_in  = 1'b0;
                  end
                  hold_valid_in = 1'b1;
                  hold_row_in   = y_ff;
                  hold_mask_in  = row_mask;
               end
               y_in     = y_ff + RW'(1);
               state_in = row_end ? csrast_pkg::ST_FLUSH : csrast_pkg::ST_ROW_START;
            end
         end

         // send the buffered row as the final one
         csrast_pkg::ST_FLUSH: begin
            if (!hold_valid_ff) begin
               state_in = csrast_pkg::ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_row_in    = hold_row_ff;
               rsp_mask_in   = hold_mask_ff;
               rsp_glyph_in  = glyph_ff;
               rsp_color_in  = color_ff;
               rsp_last_in   = 1'b1;
               hold_valid_in = 1'b0;
               state_in      = csrast_pkg::ST_IDLE;
            end
         end

         default: state_in = csrast_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scr_w_ff      <= DW'(30);
         scr_h_ff      <= DW'(30);
         ofs_x_ff      <= '0;
         ofs_y_ff      <= '0;
         state_ff      <= csrast_pkg::ST_IDLE;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         scr_w_ff      <= scr_w_in;
         scr_h_ff      <= scr_h_in;
         ofs_x_ff      <= ofs_x_in;
         ofs_y_ff      <= ofs_y_in;
         state_ff      <= state_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      mode_ff      <= mode_in;
      glyph_ff     <= glyph_in;
      color_ff     <= color_in;
      r_ff         <= r_in;
      rw_ff        <= rw_in;
      rh_ff        <= rh_in;
      cx_ff        <= cx_in;
      py_ff        <= py_in;
      x1s_ff       <= x1s_in;
      y1_ff        <= y1_in;
      len_ff       <= len_in;
      alen_ff      <= alen_in;
      neg_ff       <= neg_in;
      xmaj_ff      <= xmaj_in;
      zero_ff      <= zero_in;
      y_ff         <= y_in;
      m_ff         <= m_in;
      opa_ff       <= opa_in;
      opb_ff       <= opb_in;
      inner_ff     <= inner_in;
      res_a_ff     <= res_a_in;
      span_ff      <= span_in;
      hold_row_ff  <= hold_row_in;
      hold_mask_ff <= hold_mask_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_mask_ff  <= rsp_mask_in;
      rsp_glyph_ff <= rsp_glyph_in;
      rsp_color_ff <= rsp_color_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_row         = rsp_row_ff;
   assign rsp_column_mask = rsp_mask_ff;
   assign rsp_glyph_res   = rsp_glyph_ff;
   assign rsp_paint_color = rsp_color_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

// File: bench/cell_shape_rasterizer_checker.sv
// Row mask predictor and result checker for the cell shape rasterizer.
`timescale 1ns / 1ps
module cell_shape_rasterizer_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic [1:0]        req_mode,
   input  logic [7:0]        req_glyph,
   input  logic [7:0]        req_color,
   input  logic signed [7:0] req_pos_x,
   input  logic signed [7:0] req_pos_y,
   input  logic signed [7:0] req_end_x,
   input  logic signed [7:0] req_end_y,
   input  logic [4:0]        req_radius,
   input  logic [6:0]        req_rect_width,
   input  logic [6:0]        req_rect_height,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic [5:0]        rsp_row,
   input  logic [63:0]       rsp_column_mask,
   input  logic [7:0]        rsp_glyph_res,
   input  logic [7:0]        rsp_paint_color,
   input  logic              rsp_last,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [7:0]        csr_wdata,
   output int                fail_count,
   output int                pending_rows,
   output int                row_count
);

   typedef struct {
      logic [5:0]  row;
      logic [63:0] mask;
      logic [7:0]  glyph;
      logic [7:0]  color;
      logic        last;
   } row_result_type;

   row_result_type expected_rows[$];
   logic [63:0] masks[64];
   int scr_w, scr_h, off_x, off_y, vis_w, vis_h;

   assign pending_rows = expected_rows.size();

   function automatic void paint_cell(int x, int y);
      int px, py;
      px = x + off_x;
      py = y + off_y;
      if (px >= 0 && px < vis_w && py >= 0 && py < vis_h)
         masks[py][px] = 1'b1;
   endfunction

   function automatic void paint_line(int x1, int y1, int x2, int y2);
      int w, h, s;
      w = x2 - x1;
      h = y2 - y1;
      if (w == 0 && h == 0) begin
         paint_cell(x1, y1);
         return;
      end
      // swap so the major axis runs forward; SV int division truncates toward zero
      if ((w < 0 ? -w : w) > (h < 0 ? -h : h)) begin
         if (w < 0) begin
            s = x1; x1 = x2; x2 = s;
            s = y1; y1 = y2; y2 = s;
            w = -w; h = -h;
         end
         for (int t = 0; t < w; t++) paint_cell(x1 + t, y1 + (t * h) / w);
      end else begin
         if (h < 0) begin
            s = x1; x1 = x2; x2 = s;
            s = y1; y1 = y2; y2 = s;
            w = -w; h = -h;
         end
         for (int t = 0; t < h; t++) paint_cell(x1 + (t * w) / h, y1 + t);
      end
   endfunction

   task automatic rasterize_shape();
      int r, rr, d, n;
      row_result_type res;
      vis_w = scr_w > 64 ? 64 : scr_w;
      vis_h = scr_h > 64 ? 64 : scr_h;
      foreach (masks[k]) masks[k] = '0;
      r = req_radius;
      rr = r * r;
      case (csrast_pkg::mode_type'(req_mode))
         csrast_pkg::MODE_DISK, csrast_pkg::MODE_RING: begin
            for (int i = -r; i <= r; i++)
               for (int j = -r; j <= r; j++) begin
                  d = i * i + j * j;
                  if (req_mode == csrast_pkg::MODE_RING ? (rr >= d - r && rr <= d + r)
                                                        : (rr >= d))
                     paint_cell(req_pos_x + j, req_pos_y + i);
               end
         end
         csrast_pkg::MODE_LINE: paint_line(req_pos_x, req_pos_y, req_end_x, req_end_y);
         default: begin
            for (int i = 0; i < req_rect_height; i++)
               for (int j = 0; j < req_rect_width; j++)
                  paint_cell(req_pos_x + j, req_pos_y + i);
         end
      endcase
      n = 0;
      for (int k = 0; k < 64; k++) begin
         if (masks[k] != 0) begin
            res.row = 6'(k);
            res.mask = masks[k];
            res.glyph = req_glyph;
            res.color = req_color;
            res.last = 1'b0;
            expected_rows.push_back(res);
            n++;
         end
      end
      if (n > 0) expected_rows[expected_rows.size()-1].last = 1'b1;
   endtask

   always @(posedge clock) begin
      row_result_type want;
      int errs;
      if (reset) begin
         scr_w <= 30;
         scr_h <= 30;
         off_x <= 0;
         off_y <= 0;
         fail_count <= 0;
         row_count <= 0;
         expected_rows.delete();
      end else begin
         // track register writes
         if (csr_valid && csr_ready) begin
            case (csrast_pkg::csr_index_type'(csr_index))
               csrast_pkg::CSR_SCREEN_WIDTH:  scr_w <= csr_wdata[6:0];
               csrast_pkg::CSR_SCREEN_HEIGHT: scr_h <= csr_wdata[6:0];
               csrast_pkg::CSR_OFFSET_X:      off_x <= $signed(csr_wdata);
               default:                       off_y <= $signed(csr_wdata);
            endcase
         end
         if (req_valid && !req_stall) rasterize_shape();
         // compare each result transfer with the oldest expected row
         if (rsp_valid && !rsp_stall) begin
            row_count <= row_count + 1;
            errs = 0;
            if (expected_rows.size() == 0) begin
               $error("unexpected row result row=%0d", rsp_row);
               errs = 1;
            end else begin
               want = expected_rows.pop_front();
               if (rsp_row !== want.row) begin
                  $error("row: expected %0d actual %0d", want.row, rsp_row);
                  errs++;
               end
               if (rsp_column_mask !== want.mask) begin
                  $error("column_mask: expected %h actual %h", want.mask, rsp_column_mask);
                  errs++;
               end
               if (rsp_glyph_res !== want.glyph) begin
                  $error("glyph_res: expected %h actual %h", want.glyph, rsp_glyph_res);
                  errs++;
               end
               if (rsp_paint_color !== want.color) begin
                  $error("paint_color: expected %h actual %h", want.color, rsp_paint_color);
                  errs++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0d actual %0d", want.last, rsp_last);
                  errs++;
               end
            end
            fail_count <= fail_count + errs;
         end
      end
   end
endmodule

// File: bench/cell_shape_rasterizer_tb.sv
// Stimulus and verdict for the cell shape rasterizer testbench.
`timescale 1ns / 1ps
module cell_shape_rasterizer_tb;

   logic clock = 1'b0, reset = 1'b1;
   logic req_valid = 1'b0, rsp_stall = 1'b0, csr_valid = 1'b0;
   logic req_stall, rsp_valid, rsp_last, csr_ready;
   logic [1:0] req_mode = '0, csr_index = '0;
   logic [7:0] req_glyph = '0, req_color = '0, csr_wdata = '0;
   logic signed [7:0] req_pos_x = '0, req_pos_y = '0, req_end_x = '0, req_end_y = '0;
   logic [4:0] req_radius = '0;
   logic [6:0] req_rect_width = '0, req_rect_height = '0;
   logic [5:0] rsp_row;
   logic [63:0] rsp_column_mask;
   logic [7:0] rsp_glyph_res, rsp_paint_color;
   int fail_count, pending_rows, row_count, shape_count;
   bit quiet_tail = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   cell_shape_rasterizer dut (.*);
   cell_shape_rasterizer_checker checker_i (.*);

   // receiver stalls in random bursts, none in the tail
   initial begin
      int n;
      @(posedge clock iff !reset);
      forever begin
         n = $urandom_range(1, 10);
         rsp_stall <= !quiet_tail && ($urandom_range(0, 2) == 0);
         repeat (n) @(posedge clock);
      end
   end

   initial begin
      #400ms;
      $display("CHECK FAILED");
      $finish;
   end

   task automatic write_reg(csrast_pkg::csr_index_type idx, logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock iff csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_screen(int w, int h, int ox, int oy);
      write_reg(csrast_pkg::CSR_SCREEN_WIDTH, 8'(w));
      write_reg(csrast_pkg::CSR_SCREEN_HEIGHT, 8'(h));
      write_reg(csrast_pkg::CSR_OFFSET_X, 8'(ox));
      write_reg(csrast_pkg::CSR_OFFSET_Y, 8'(oy));
   endtask

   // let the block drain before touching registers
   task automatic wait_idle();
      int guard = 0;
      while ((pending_rows != 0 || req_stall) && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      repeat (3000) @(posedge clock);
   endtask

   task automatic send_shape(csrast_pkg::mode_type m, int px, int py, int ex, int ey,
                             int r, int rw, int rh);
      if (!quiet_tail && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 10)) @(posedge clock);
      req_valid <= 1'b1;
      req_mode <= m;
      req_glyph <= 8'($urandom);
      req_color <= 8'($urandom);
      req_pos_x <= 8'(px);
      req_pos_y <= 8'(py);
      req_end_x <= 8'(ex);
      req_end_y <= 8'(ey);
      req_radius <= 5'(r);
      req_rect_width <= 7'(rw);
      req_rect_height <= 7'(rh);
      @(posedge clock iff !req_stall);
      req_valid <= 1'b0;
      shape_count++;
      @(posedge clock);
   endtask

   // mostly shapes near the screen, sometimes anywhere in range
   task automatic random_shape();
      int lo, hi;
      bit wide;
      wide = $urandom_range(0, 4) == 0;
      lo = wide ? -128 : -10;
      hi = wide ? 127 : 70;
      send_shape(csrast_pkg::mode_type'($urandom_range(0, 3)),
                 $urandom_range(lo + 128, hi + 128) - 128,
                 $urandom_range(lo + 128, hi + 128) - 128,
                 $urandom_range(lo + 128, hi + 128) - 128,
                 $urandom_range(lo + 128, hi + 128) - 128,
                 $urandom_range(0, 31), $urandom_range(0, 64), $urandom_range(0, 64));
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed shapes at reset screen
      send_shape(csrast_pkg::MODE_DISK, 10, 10, 0, 0, 0, 0, 0);
      send_shape(csrast_pkg::MODE_DISK, 15, 15, 0, 0, 31, 0, 0);
      send_shape(csrast_pkg::MODE_RING, 15, 15, 0, 0, 31, 0, 0);
      send_shape(csrast_pkg::MODE_RING, 5, 5, 0, 0, 4, 0, 0);
      send_shape(csrast_pkg::MODE_LINE, 3, 4, 3, 4, 0, 0, 0);
      send_shape(csrast_pkg::MODE_LINE, 0, 0, 29, 7, 0, 0, 0);
      send_shape(csrast_pkg::MODE_LINE, 29, 7, 0, 0, 0, 0, 0);
      send_shape(csrast_pkg::MODE_LINE, 5, 29, 9, -3, 0, 0, 0);
      send_shape(csrast_pkg::MODE_LINE, -128, -128, 127, 127, 0, 0, 0);
      send_shape(csrast_pkg::MODE_LINE, 127, -128, -128, 127, 0, 0, 0);
      send_shape(csrast_pkg::MODE_RECT, 2, 3, 0, 0, 0, 0, 5);
      send_shape(csrast_pkg::MODE_RECT, 2, 3, 0, 0, 0, 5, 0);
      send_shape(csrast_pkg::MODE_RECT, -128, -128, 0, 0, 0, 64, 64);
      send_shape(csrast_pkg::MODE_RECT, 127, 127, 0, 0, 0, 64, 64);
      send_shape(csrast_pkg::MODE_DISK, -100, -100, 0, 0, 5, 0, 0);
      wait_idle();
      set_screen(64, 64, 0, 0);
      send_shape(csrast_pkg::MODE_RECT, 0, 0, 0, 0, 0, 64, 64);
      send_shape(csrast_pkg::MODE_DISK, 32, 32, 0, 0, 31, 0, 0);
      send_shape(csrast_pkg::MODE_LINE, 0, 63, 63, 0, 0, 0, 0);
      wait_idle();
      set_screen(127, 127, 127, 128);
      send_shape(csrast_pkg::MODE_RECT, -128, 100, 0, 0, 0, 64, 64);
      wait_idle();
      set_screen(0, 0, 0, 0);
      send_shape(csrast_pkg::MODE_RECT, 0, 0, 0, 0, 0, 10, 10);
      wait_idle();
      set_screen(1, 1, 0, 0);
      send_shape(csrast_pkg::MODE_DISK, 0, 0, 0, 0, 3, 0, 0);
      // random phases over several screen settings
      for (int phase = 0; phase < 6; phase++) begin
         wait_idle();
         case (phase)
            0: set_screen(64, 64, $urandom_range(0, 255), $urandom_range(0, 255));
            1: set_screen($urandom_range(1, 64), $urandom_range(1, 64), 0, 0);
            2: set_screen(30, 30, 8'h80, 8'h7F);
            3: set_screen($urandom_range(65, 127), $urandom_range(1, 127), $urandom, $urandom);
            default: set_screen($urandom_range(8, 64), $urandom_range(8, 64), 0, 0);
         endcase
         if (phase == 5) quiet_tail = 1;
         repeat (55) random_shape();
      end
      wait_idle();
      $display("Sent %0d shapes over several screen sizes and offsets; checked %0d row results.",
               shape_count, row_count);
      if (fail_count == 0 && pending_rows == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule
